// ===== hdl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, types and constants for the trimmed sum of samples block.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int unsigned SampleW            = 32;
  localparam int unsigned SumW               = 42;
  localparam int unsigned TrackDepth         = 3;
  localparam int unsigned TrimW              = SampleW + $clog2(TrackDepth);
  localparam int unsigned TotalTrimW         = TrimW + 1;
  localparam int unsigned SkipCount          = 2;
  localparam int unsigned SampleCountDefault = 28;

  typedef logic [SampleW-1:0]    sample_t;
  typedef logic [SumW-1:0]       sum_t;
  typedef logic [TrimW-1:0]      trim_t;
  typedef logic [TotalTrimW-1:0] total_trim_t;

endpackage : tss_pkg

`default_nettype wire

// ===== hdl/tss_if.sv =====
// ----------------------------------------------------------------------------
// tss_if
// Valid/ready channels for sample words in and trimmed sum words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_sample_if;
  import tss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : tss_sample_if

interface tss_result_if;
  import tss_pkg::*;

  logic valid;
  logic ready;
  sum_t trimmed_sum;

  modport source (output valid, output trimmed_sum, input ready);
  modport sink   (input valid, input trimmed_sum, output ready);
endinterface : tss_result_if

`default_nettype wire

// ===== hdl/trimmed_sum_of_samples.sv =====
// ----------------------------------------------------------------------------
// trimmed_sum_of_samples
// Trimmed sum over batches of timing samples.
// ----------------------------------------------------------------------------
// Takes one 32-bit sample word per cycle while ready is high. Each batch is
// SAMPLE_COUNT words; the first two are dropped, the rest are summed while two
// chains of three sorted cells track the three largest and three smallest
// values. After the last word of a batch the block emits one word, the sum
// minus those six values, through a two-stage adder pipeline and an output
// register. The next batch streams in meanwhile; ready drops only on the last
// word of a batch while the previous batch's result is still in the pipeline
// or waiting at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_sum_of_samples
  import tss_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT = SampleCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tss_sample_if.sink   sample_i,
  tss_result_if.source result_o
);

  localparam int unsigned IdxW = $clog2(SAMPLE_COUNT);

  logic [IdxW-1:0] idx_q, idx_d;
  sum_t            sum_q, sum_d;
  logic            fin_q;
  logic            accept, is_last, keep, clear, update, busy;

  sample_t large_val [TrackDepth];
  sample_t small_val [TrackDepth];
  logic    large_gt  [TrackDepth];
  logic    small_gt  [TrackDepth];

  assign accept  = sample_i.valid && sample_i.ready;
  assign is_last = idx_q >= IdxW'(SAMPLE_COUNT - 1);
  assign keep    = idx_q >= IdxW'(SkipCount);
  assign clear   = accept && (idx_q == '0);
  assign update  = accept && keep;

  assign sample_i.ready = !(is_last && busy);

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (accept) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
    if (clear) begin
      sum_d = '0;
    end else if (update) begin
      sum_d = sum_q + SumW'(sample_i.sample);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
      fin_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      fin_q <= accept && is_last;
    end
  end

  for (genvar i = 0; i < TrackDepth; i++) begin : g_chain
    if (i == 0) begin : g_head
      tss_cell #(.Largest(1'b1)) u_large (
        .clk_i, .rst_ni, .clear_i(clear), .update_i(update),
        .sample_i(sample_i.sample), .prev_val_i(sample_i.sample), .prev_gt_i(1'b0),
        .val_o(large_val[i]), .gt_o(large_gt[i])
      );
      tss_cell #(.Largest(1'b0)) u_small (
        .clk_i, .rst_ni, .clear_i(clear), .update_i(update),
        .sample_i(sample_i.sample), .prev_val_i(sample_i.sample), .prev_gt_i(1'b0),
        .val_o(small_val[i]), .gt_o(small_gt[i])
      );
    end else begin : g_body
      tss_cell #(.Largest(1'b1)) u_large (
        .clk_i, .rst_ni, .clear_i(clear), .update_i(update),
        .sample_i(sample_i.sample), .prev_val_i(large_val[i-1]),
        .prev_gt_i(large_gt[i-1]), .val_o(large_val[i]), .gt_o(large_gt[i])
      );
      tss_cell #(.Largest(1'b0)) u_small (
        .clk_i, .rst_ni, .clear_i(clear), .update_i(update),
        .sample_i(sample_i.sample), .prev_val_i(small_val[i-1]),
        .prev_gt_i(small_gt[i-1]), .val_o(small_val[i]), .gt_o(small_gt[i])
      );
    end
  end

  tss_trim u_trim (
    .clk_i,
    .rst_ni,
    .start_i (fin_q),
    .sum_i   (sum_q),
    .large_i (large_val),
    .small_i (small_val),
    .busy_o  (busy),
    .result_o(result_o)
  );

`ifndef SYNTHESIS
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready && is_last) |-> ##4 result_o.valid)
    else $error("result word missing four cycles after last sample");

  a_large_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (large_val[0] >= large_val[1]) && (large_val[1] >= large_val[2]))
    else $error("largest chain out of order");

  a_small_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (small_val[0] <= small_val[1]) && (small_val[1] <= small_val[2]))
    else $error("smallest chain out of order");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(SAMPLE_COUNT - 1))
    else $error("sample index past end of batch");
`endif

endmodule : trimmed_sum_of_samples

`default_nettype wire

// ===== hdl/tss_cell.sv =====
// ----------------------------------------------------------------------------
// tss_cell
// One slot of a sorted order-statistic chain. Compares the broadcast sample
// against its own value and takes either the sample or its neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_cell
  import tss_pkg::*;
#(
  parameter bit Largest = 1'b1
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clear_i,
  input  logic    update_i,
  input  sample_t sample_i,
  input  sample_t prev_val_i,
  input  logic    prev_gt_i,
  output sample_t val_o,
  output logic    gt_o
);

  localparam sample_t InitVal = Largest ? {SampleW{1'b0}} : {SampleW{1'b1}};

  sample_t val_q, val_d;

  assign gt_o  = Largest ? (sample_i > val_q) : (sample_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (clear_i) begin
      val_d = InitVal;
    end else if (update_i && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= InitVal;
    end else begin
      val_q <= val_d;
    end
  end

endmodule : tss_cell

`default_nettype wire

// ===== hdl/tss_trim.sv =====
// ----------------------------------------------------------------------------
// tss_trim
// Result pipeline: adds up the tracked extremes, subtracts them from the
// batch sum and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_trim
  import tss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  sum_t    sum_i,
  input  sample_t large_i [TrackDepth],
  input  sample_t small_i [TrackDepth],
  output logic    busy_o,
  tss_result_if.source result_o
);

  logic        s1_valid_q, s2_valid_q, out_valid_q, out_valid_d;
  sum_t        s1_sum_q, s2_sum_q, out_data_q;
  trim_t       s1_large_q, s1_small_q, large_sum, small_sum;
  total_trim_t s2_trim_q;

  always_comb begin
    large_sum = '0;
    small_sum = '0;
    for (int i = 0; i < TrackDepth; i++) begin
      large_sum = large_sum + TrimW'(large_i[i]);
      small_sum = small_sum + TrimW'(small_i[i]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_valid_q) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_sum_q   <= sum_i;
      s1_large_q <= large_sum;
      s1_small_q <= small_sum;
    end
    if (s1_valid_q) begin
      s2_sum_q  <= s1_sum_q;
      s2_trim_q <= TotalTrimW'(s1_large_q) + TotalTrimW'(s1_small_q);
    end
    if (s2_valid_q) begin
      out_data_q <= s2_sum_q - SumW'(s2_trim_q);
    end
  end

  assign busy_o               = s1_valid_q || s2_valid_q || out_valid_q;
  assign result_o.valid       = out_valid_q;
  assign result_o.trimmed_sum = out_data_q;

endmodule : tss_trim

`default_nettype wire
